>>> sv/bbc_pkg.sv
// Shared types and constants for the block buffer cache LRU core.
// Depends on nothing; imported by every module of the core.
package bbc_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] SCAN_LAST = SLOT_W'(NUM_SLOTS - 1);

    localparam logic [1:0] OP_GET     = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_PIN     = 2'd2;
    localparam logic [1:0] OP_UNPIN   = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOFREE = 2'd1;
    localparam logic [1:0] STAT_UNDER  = 2'd2;

    localparam logic [7:0] REF_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [7:0]  refc;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [4:0]  slot;
        logic [31:0] tick;
    } req_t;

    typedef struct packed {
        logic [4:0] slot;
        logic       hit;
        logic       rd;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              set_dv;
    } mem_req_t;

    typedef struct packed {
        entry_t ent;
        logic   dv;
    } mem_rsp_t;

endpackage

>>> sv/block_buffer_cache_lru_core.sv
// Block buffer cache tag and LRU replacement engine, top level.
// Depends on bbc_pkg, bbc_store and bbc_ctrl.
//
// One request is handled at a time. A get walks every slot of the slot store,
// one entry per cycle, looking for the tag and the oldest free slot.
// Release, pin and unpin do one read-modify-write of the addressed slot.
// Results sit in an output register, so a new request is taken while the
// previous result waits on m_tready.
module block_buffer_cache_lru_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // device_id[7:0], block_number[39:8],
                                   // slot_index[44:40], tick_now[76:45], zero pad
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // result_slot[4:0], was_hit[5], needs_read[6],
                                   // status[8:7], zero pad
);
    import bbc_pkg::*;

    req_t     in_req;
    rsp_t     done_rsp;
    logic     done_valid;
    logic     done_ready;
    mem_req_t mreq;
    mem_rsp_t mrsp;

    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    assign in_req.op   = s_tuser;
    assign in_req.dev  = s_tdata[7:0];
    assign in_req.blk  = s_tdata[39:8];
    assign in_req.slot = s_tdata[44:40];
    assign in_req.tick = s_tdata[76:45];

    assign done_ready = !out_valid_reg || m_tready;

    bbc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_req     (in_req),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .done_ready (done_ready),
        .done_valid (done_valid),
        .done_rsp   (done_rsp),
        .mreq       (mreq),
        .mrsp       (mrsp)
    );

    bbc_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (done_valid && done_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_valid && done_ready) begin
            out_data_reg <= {7'd0, done_rsp.status, done_rsp.rd, done_rsp.hit, done_rsp.slot};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> sv/bbc_store.sv
// Slot store: one-port-read, one-port-write memory of tag/count/stamp entries
// with per-slot init and data-valid bits. Depends on bbc_pkg.
module bbc_store (
    input  logic              aclk,
    input  logic              aresetn,
    input  bbc_pkg::mem_req_t req,
    output bbc_pkg::mem_rsp_t rsp
);
    import bbc_pkg::*;

    entry_t                 mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   init_reg;
    logic [NUM_SLOTS-1:0]   dv_reg;
    entry_t                 rdata_reg;
    logic                   rinit_reg;
    logic                   rdv_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rdata_reg <= mem[req.rd_addr];
            rinit_reg <= init_reg[req.rd_addr];
            rdv_reg   <= dv_reg[req.rd_addr];
        end
    end

    // never-written entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= '0;
            dv_reg   <= '0;
        end else if (req.wr_en) begin
            init_reg[req.wr_addr] <= 1'b1;
            if (req.set_dv) begin
                dv_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rsp.ent = rinit_reg ? rdata_reg : '0;
    assign rsp.dv  = rdv_reg;

endmodule

>>> sv/bbc_ctrl.sv
// Request sequencer: slot scan for get, read-modify-write for release/pin/unpin.
// Depends on bbc_pkg; drives bbc_store.
module bbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  bbc_pkg::req_t     in_req,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              done_ready,
    output logic              done_valid,
    output bbc_pkg::rsp_t     done_rsp,
    output bbc_pkg::mem_req_t mreq,
    input  bbc_pkg::mem_rsp_t mrsp
);
    import bbc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_OPRD  = 3'd3;
    localparam logic [2:0] S_OPCAP = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    req_t              req_reg, req_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pidx_reg, pidx_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] hidx_reg, hidx_next;
    entry_t            ent_reg, ent_next;
    logic              edv_reg, edv_next;
    logic              free_reg, free_next;
    logic [SLOT_W-1:0] vidx_reg, vidx_next;
    logic [31:0]       vstamp_reg, vstamp_next;

    logic              scan_valid;
    logic              tag_match;
    logic              in_range;
    logic [7:0]        ref_inc;
    entry_t            wr_ent;
    logic              wr_req;
    logic [SLOT_W-1:0] wr_addr;
    logic              wr_set_dv;

    assign scan_valid = pend_reg && (state_reg == S_SCAN || state_reg == S_DRAIN);
    assign tag_match  = (mrsp.ent.dev == req_reg.dev) && (mrsp.ent.blk == req_reg.blk);
    assign in_range   = 32'(req_reg.slot) < 32'(NUM_SLOTS);
    assign ref_inc    = (ent_reg.refc == REF_MAX) ? ent_reg.refc : ent_reg.refc + 8'd1;

    // result and write-back of the finished request
    always_comb begin
        wr_ent          = ent_reg;
        wr_req          = 1'b0;
        done_rsp.slot   = req_reg.slot;
        done_rsp.hit    = 1'b0;
        done_rsp.rd     = 1'b0;
        done_rsp.status = STAT_OK;
        wr_set_dv       = 1'b0;
        wr_addr         = SLOT_W'(req_reg.slot);
        if (req_reg.op == OP_GET) begin
            wr_set_dv = 1'b1;
            if (found_reg) begin
                wr_req        = 1'b1;
                wr_addr       = hidx_reg;
                wr_ent.refc   = ref_inc;
                done_rsp.slot = 5'(hidx_reg);
                done_rsp.hit  = 1'b1;
                done_rsp.rd   = !edv_reg;
            end else if (free_reg) begin
                wr_req        = 1'b1;
                wr_addr       = vidx_reg;
                wr_ent.dev    = req_reg.dev;
                wr_ent.blk    = req_reg.blk;
                wr_ent.refc   = 8'd1;
                wr_ent.stamp  = vstamp_reg;
                done_rsp.slot = 5'(vidx_reg);
                done_rsp.rd   = 1'b1;
            end else begin
                done_rsp.slot   = 5'd0;
                done_rsp.status = STAT_NOFREE;
            end
        end else if (in_range) begin
            if (req_reg.op == OP_PIN) begin
                wr_req      = 1'b1;
                wr_ent.refc = ref_inc;
            end else if (ent_reg.refc == 8'd0) begin
                done_rsp.status = STAT_UNDER;
            end else begin
                wr_req      = 1'b1;
                wr_ent.refc = ent_reg.refc - 8'd1;
                if (req_reg.op == OP_RELEASE && ent_reg.refc == 8'd1) begin
                    wr_ent.stamp = req_reg.tick;
                end
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        pidx_next    = pidx_reg;
        found_next   = found_reg;
        hidx_next    = hidx_reg;
        ent_next     = ent_reg;
        edv_next     = edv_reg;
        free_next    = free_reg;
        vidx_next    = vidx_reg;
        vstamp_next  = vstamp_reg;
        in_ready     = 1'b0;
        done_valid   = 1'b0;
        mreq.rd_en   = 1'b0;
        mreq.rd_addr = cnt_reg;
        mreq.wr_en   = 1'b0;
        mreq.wr_addr = wr_addr;
        mreq.wr_data = wr_ent;
        mreq.set_dv  = wr_set_dv;

        if (scan_valid) begin
            if (!found_reg && tag_match) begin
                found_next = 1'b1;
                hidx_next  = pidx_reg;
                ent_next   = mrsp.ent;
                edv_next   = mrsp.dv;
            end
            if (mrsp.ent.refc == 8'd0 && (!free_reg || mrsp.ent.stamp < vstamp_reg)) begin
                free_next   = 1'b1;
                vidx_next   = pidx_reg;
                vstamp_next = mrsp.ent.stamp;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next = in_req;
                    if (in_req.op == OP_GET) begin
                        state_next = S_SCAN;
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        found_next = 1'b0;
                        free_next  = 1'b0;
                    end else begin
                        state_next = S_OPRD;
                    end
                end
            end
            S_SCAN: begin
                mreq.rd_en = 1'b1;
                pend_next  = 1'b1;
                pidx_next  = cnt_reg;
                if (cnt_reg == SCAN_LAST) begin
                    state_next = S_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                pend_next  = 1'b0;
                state_next = S_DONE;
            end
            S_OPRD: begin
                if (in_range) begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = SLOT_W'(req_reg.slot);
                    state_next   = S_OPCAP;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_OPCAP: begin
                ent_next   = mrsp.ent;
                state_next = S_DONE;
            end
            S_DONE: begin
                done_valid = 1'b1;
                if (done_ready) begin
                    mreq.wr_en = wr_req;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        cnt_reg    <= cnt_next;
        pidx_reg   <= pidx_next;
        hidx_reg   <= hidx_next;
        ent_reg    <= ent_next;
        edv_reg    <= edv_next;
        vidx_reg   <= vidx_next;
        vstamp_reg <= vstamp_next;
    end

`ifndef ASSERT_OFF
    a_wr_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.wr_en |-> (state_reg == S_DONE && done_ready))
        else $error("store write outside completion");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mreq.rd_en && mreq.wr_en))
        else $error("store read and write in one cycle");

    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && cnt_reg != SCAN_LAST)
        |=> (state_reg == S_SCAN && cnt_reg == SLOT_W'($past(cnt_reg) + 1'b1)))
        else $error("scan counter skipped a slot");

    a_nofree_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_valid && done_rsp.status == STAT_NOFREE) |-> (!free_reg && !found_reg))
        else $error("no-free status with a candidate slot");
`endif

endmodule
